@@ hw/rtl/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants for the minimum coin change core
// Microcode ROM, step and condition codes, control and status words.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // Default sizes
  localparam int MAX_SUM_DEF   = 1024;
  localparam int MAX_COINS_DEF = 16;

  // Fixed payload widths
  localparam int COIN_W = 11;
  localparam int TGT_W  = 11;
  localparam int OUT_W  = 11;

  // Sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM_TOP,
    ST_K_ISSUE,
    ST_COIN_CHK,
    ST_UPDATE,
    ST_WRITE,
    ST_FINISH,
    ST_RESULT
  } step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOT_LAST,
    C_TGT_BIG,
    C_S_GT_TGT,
    C_K_DONE,
    C_SKIP,
    C_OUT_BUSY
  } cond_t;

  // One microcode word: taken jump goes to tgt_t, otherwise to tgt_f
  typedef struct packed {
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
    logic  in_rdy;    // take an input beat
    logic  init;      // table[0] = 0, sum = 1
    logic  k_clr;     // coin index = 0, best = infinity
    logic  coin_rd;   // read coin at index
    logic  k_inc;     // advance coin index
    logic  best_rd;   // read table at sum - coin
    logic  best_upd;  // fold candidate into best
    logic  best_wr;   // table[sum] = best, sum++
    logic  tgt_rd;    // read table at target
    logic  res_ld;    // load result register
  } ctl_word_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic not_last;
    logic tgt_big;
    logic s_gt_tgt;
    logic k_done;
    logic skip;
    logic out_busy;
  } stat_t;

  // Microcode ROM
  function automatic ctl_word_t ucode(step_t st);
    ctl_word_t w;
    w = '0;
    w.cond  = C_ALWAYS;
    w.tgt_t = ST_IDLE;
    w.tgt_f = ST_IDLE;
    case (st)
      ST_IDLE: begin
        w.cond = C_NOT_LAST; w.tgt_t = ST_IDLE; w.tgt_f = ST_CHECK;
        w.in_rdy = 1'b1;
      end
      ST_CHECK: begin
        w.cond = C_TGT_BIG; w.tgt_t = ST_RESULT; w.tgt_f = ST_SUM_TOP;
        w.init = 1'b1;
      end
      ST_SUM_TOP: begin
        w.cond = C_S_GT_TGT; w.tgt_t = ST_FINISH; w.tgt_f = ST_K_ISSUE;
        w.k_clr = 1'b1;
      end
      ST_K_ISSUE: begin
        w.cond = C_K_DONE; w.tgt_t = ST_WRITE; w.tgt_f = ST_COIN_CHK;
        w.coin_rd = 1'b1;
      end
      ST_COIN_CHK: begin
        w.cond = C_SKIP; w.tgt_t = ST_K_ISSUE; w.tgt_f = ST_UPDATE;
        w.k_inc = 1'b1; w.best_rd = 1'b1;
      end
      ST_UPDATE: begin
        w.cond = C_ALWAYS; w.tgt_t = ST_K_ISSUE; w.tgt_f = ST_K_ISSUE;
        w.best_upd = 1'b1;
      end
      ST_WRITE: begin
        w.cond = C_ALWAYS; w.tgt_t = ST_SUM_TOP; w.tgt_f = ST_SUM_TOP;
        w.best_wr = 1'b1;
      end
      ST_FINISH: begin
        w.cond = C_ALWAYS; w.tgt_t = ST_RESULT; w.tgt_f = ST_RESULT;
        w.tgt_rd = 1'b1;
      end
      ST_RESULT: begin
        w.cond = C_OUT_BUSY; w.tgt_t = ST_RESULT; w.tgt_f = ST_IDLE;
        w.res_ld = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.tgt_t = ST_IDLE; w.tgt_f = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/mcc_in_if.sv @@
// ----------------------------------------------------------------------------
// mcc_in_if: coin input channel
// Valid/ready channel carrying one coin and, on the last beat, the target.
// ----------------------------------------------------------------------------
interface mcc_in_if;
  import mcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [COIN_W-1:0] coin_value;
  logic              is_last;
  logic [TGT_W-1:0]  target_sum;

  modport source (output valid, output coin_value, output is_last,
                  output target_sum, input ready);
  modport sink   (input valid, input coin_value, input is_last,
                  input target_sum, output ready);
endinterface

@@ hw/rtl/mcc_out_if.sv @@
// ----------------------------------------------------------------------------
// mcc_out_if: result channel
// Valid/ready channel carrying the minimum coin count and reachable flag.
// ----------------------------------------------------------------------------
interface mcc_out_if;
  import mcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] min_coins;
  logic             reachable;

  modport source (output valid, output min_coins, output reachable,
                  input ready);
  modport sink   (input valid, input min_coins, input reachable,
                  output ready);
endinterface

@@ hw/rtl/mcc_seq.sv @@
// ----------------------------------------------------------------------------
// mcc_seq: microcode sequencer
// Step counter over the ROM; each word picks one of two successors by a flag.
// ----------------------------------------------------------------------------
module mcc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  mcc_pkg::stat_t     stat,
  output mcc_pkg::ctl_word_t ctl,
  output mcc_pkg::step_t     step
);
  import mcc_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take;

  // Step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // ROM lookup and branch
  always_comb begin
    ctl = ucode(step_r);
    case (ctl.cond)
      C_ALWAYS:   take = 1'b1;
      C_NOT_LAST: take = stat.not_last;
      C_TGT_BIG:  take = stat.tgt_big;
      C_S_GT_TGT: take = stat.s_gt_tgt;
      C_K_DONE:   take = stat.k_done;
      C_SKIP:     take = stat.skip;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b1;
    endcase
    step_nxt = take ? ctl.tgt_t : ctl.tgt_f;
  end

  assign step = step_r;

endmodule

@@ hw/rtl/min_coin_change_core.sv @@
// ----------------------------------------------------------------------------
// min_coin_change_core: fewest coins for a target sum, unbounded coin reuse
// Coins load into a small memory; a microcoded sweep fills the count table.
// ----------------------------------------------------------------------------
// Sequence: a non-last coin beat is taken in the idle step, which stays ready for more.
//   A last beat starts the target check and the table sweep, paced by one table
//   memory port and one coin compare per step; a target above MAX_SUM skips it.
// Throughput: one problem at a time; the next coin is taken while the result
//   still waits in the output register.
// Reset: synchronous active-low; clears the sequencer, coin count and result valid.
module min_coin_change_core #(
  parameter int MAX_SUM   = mcc_pkg::MAX_SUM_DEF,
  parameter int MAX_COINS = mcc_pkg::MAX_COINS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  mcc_in_if.sink   in_ch,
  mcc_out_if.source out_ch
);
  import mcc_pkg::*;

  localparam int CC_W  = $clog2(MAX_COINS + 1);
  localparam int CI_W  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int SUM_W = (MAX_SUM > 1) ? $clog2(MAX_SUM + 1) : 1;
  localparam int S_W   = $clog2(MAX_SUM + 2);
  localparam int CNT_W = $clog2(MAX_SUM + 2);
  localparam logic [CNT_W-1:0] INF = '1;

  ctl_word_t ctl;
  stat_t     stat;
  step_t     step;

  // Coin storage and problem registers
  logic [COIN_W-1:0] coin_mem [MAX_COINS];
  logic [COIN_W-1:0] coin_q;
  logic [CC_W-1:0]   count_r;
  logic [CC_W-1:0]   k_r;
  logic [TGT_W-1:0]  target_r;
  logic [S_W-1:0]    s_r;
  logic [CNT_W-1:0]  best_r;

  // Count table
  logic [CNT_W-1:0]  best_mem [MAX_SUM + 1];
  logic [CNT_W-1:0]  mem_q;
  logic              mem_we;
  logic [SUM_W-1:0]  mem_wa;
  logic [CNT_W-1:0]  mem_wd;
  logic              mem_re;
  logic [SUM_W-1:0]  mem_ra;

  // Result register
  logic              out_valid_r;
  logic [OUT_W-1:0]  min_r;
  logic              reach_r;

  logic              in_fire;
  logic              res_fire;
  logic [31:0]       diff;
  logic [31:0]       tgt_ext;
  logic [31:0]       cnt_ext;
  logic [CNT_W-1:0]  cand;

  mcc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl),
    .step  (step)
  );

  assign in_ch.ready = ctl.in_rdy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Flags for the sequencer
  assign tgt_ext = {{(32 - TGT_W){1'b0}}, target_r};
  assign diff    = 32'(s_r) - 32'(coin_q);
  always_comb begin
    stat.not_last = !(in_ch.valid && in_ch.is_last);
    stat.tgt_big  = tgt_ext > 32'(MAX_SUM);
    stat.s_gt_tgt = 32'(s_r) > tgt_ext;
    stat.k_done   = k_r >= count_r;
    stat.skip     = (coin_q == '0) || (32'(coin_q) > 32'(s_r));
    stat.out_busy = out_valid_r && !out_ch.ready;
  end

  assign res_fire = ctl.res_ld && !stat.out_busy;

  // Coin load, coin count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (res_fire) begin
      count_r <= '0;
    end else if (in_fire && (32'(count_r) < 32'(MAX_COINS))) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (32'(count_r) < 32'(MAX_COINS))) begin
      coin_mem[count_r[CI_W-1:0]] <= in_ch.coin_value;
    end
    if (ctl.coin_rd && !stat.k_done) begin
      coin_q <= coin_mem[k_r[CI_W-1:0]];
    end
  end

  // Sweep registers
  assign cand = (mem_q == INF) ? INF : mem_q + 1'b1;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      target_r <= in_ch.target_sum;
    end
    if (ctl.init) begin
      s_r <= S_W'(1);
    end else if (ctl.best_wr) begin
      s_r <= s_r + 1'b1;
    end
    if (ctl.k_clr) begin
      k_r    <= '0;
      best_r <= INF;
    end else begin
      if (ctl.k_inc) begin
        k_r <= k_r + 1'b1;
      end
      if (ctl.best_upd && (cand < best_r)) begin
        best_r <= cand;
      end
    end
  end

  // Table port control
  always_comb begin
    mem_we = ctl.init || ctl.best_wr;
    mem_wa = ctl.init ? '0 : s_r[SUM_W-1:0];
    mem_wd = ctl.init ? '0 : best_r;
    mem_re = ctl.tgt_rd || (ctl.best_rd && !stat.skip);
    mem_ra = ctl.tgt_rd ? tgt_ext[SUM_W-1:0] : diff[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      best_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= best_mem[mem_ra];
    end
  end

  // Result register
  assign cnt_ext = 32'(mem_q);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      if (stat.tgt_big || (mem_q == INF)) begin
        min_r   <= '0;
        reach_r <= 1'b0;
      end else begin
        min_r   <= cnt_ext[OUT_W-1:0];
        reach_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.min_coins = min_r;
  assign out_ch.reachable = reach_r;

  // Checks
  a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.is_last) |=> !in_ch.ready)
    else $error("input taken right after last coin beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_COINS))
    else $error("coin count above capacity");

  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step == ST_RESULT))
    else $error("result raised outside result step");

  a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step == ST_K_ISSUE) |-> (32'(s_r) <= tgt_ext))
    else $error("sweep sum beyond target");

endmodule
